@@ sv/cassette_block_deframer_core_defines.svh @@
// Assertion macros shared by the cassette block deframer modules.
`ifndef CASSETTE_BLOCK_DEFRAMER_CORE_DEFINES_SVH
`define CASSETTE_BLOCK_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cbd_pkg.sv @@
// Types and constants of the cassette block deframer.
package cbd_pkg;

    localparam int POSITION_BITS_DEF = 35;
    localparam int LANES             = 8;
    localparam int LANE_W            = 3;
    localparam int FILL_W            = 4;
    localparam logic [FILL_W-1:0] FILL_FULL = 4'd8;
    localparam int OFIFO_DEPTH       = 4;

    localparam logic [7:0] SYNC_RESET = 8'd60;

    // Register indexes of the configuration port
    localparam logic REG_SYNC_VALUE   = 1'b0;
    localparam logic REG_EMIT_PAYLOAD = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_TYPE   = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CHECK  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              found;
        logic [LANE_W-1:0] hit_idx;
        logic [7:0]        block_byte;
    } merge_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [7:0]  block_len;
        logic [31:0] lead_len;
        logic [31:0] sync_end;
        logic [31:0] payload_start;
        logic        sum_ok;
        logic        last;
    } result_t;

endpackage

@@ sv/cbd_lane.sv @@
// One bit-alignment lane: window extraction and sync compare.
module cbd_lane
    import cbd_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic [7:0]        prev_byte,
    input  logic [7:0]        data_byte,
    input  logic [FILL_W-1:0] fill,
    input  logic [7:0]        sync_value,
    output logic [7:0]        lane_byte,
    output logic              hit
);

    logic [15:0] stream;

    assign stream    = {data_byte, prev_byte};
    // window after bit LANE of the new byte has gone by
    assign lane_byte = stream[LANE+1 +: 8];
    assign hit       = (fill >= FILL_W'(LANES - 1 - LANE)) && (lane_byte == sync_value);

endmodule

@@ sv/cbd_merge.sv @@
// Merges lane results: earliest sync hit and the byte at the block alignment.
module cbd_merge
    import cbd_pkg::*;
(
    input  logic [LANES-1:0]      hits,
    input  logic [LANES-1:0][7:0] lane_bytes,
    input  logic [LANE_W-1:0]     align,
    output merge_t                merged
);

    always_comb
    begin
        merged.found      = |hits;
        merged.hit_idx    = '0;
        merged.block_byte = lane_bytes[align];
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                merged.hit_idx = LANE_W'(i);
            end
        end
    end

endmodule

@@ sv/cbd_out_fifo.sv @@
// Result queue taking up to two results per cycle.
`include "cassette_block_deframer_core_defines.svh"

module cbd_out_fifo
    import cbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr0_valid,
    input  result_t wr0,
    input  logic    wr1_valid,
    input  result_t wr1,
    output logic    room2,
    output logic    rd_valid,
    output result_t rd_data,
    input  logic    rd_ready
);

    localparam int PTR_W = $clog2(OFIFO_DEPTH);
    localparam int CNT_W = $clog2(OFIFO_DEPTH + 1);

    result_t            mem [OFIFO_DEPTH];
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               pop;
    logic [1:0]         push_n;

    assign pop      = rd_valid && rd_ready;
    assign push_n   = {1'b0, wr0_valid} + {1'b0, wr1_valid};
    assign room2    = cnt_reg <= CNT_W'(OFIFO_DEPTH - 2);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + PTR_W'(push_n);
        rp_next  = rp_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr0_valid)
        begin
            mem[wp_reg] <= wr0;
        end
        if (wr1_valid)
        begin
            mem[wp_reg + PTR_W'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `CBD_ASSERT_IMP(a_no_overflow, wr0_valid, room2, "result queue overflow")
    `CBD_ASSERT_IMP(a_wr_order, wr1_valid, wr0_valid, "second slot written without first")
    `CBD_ASSERT_NXT(a_pop_only, pop && !wr0_valid, cnt_reg == $past(cnt_reg) - CNT_W'(1),
        "queue count off after pop")

endmodule

@@ sv/cassette_block_deframer_core.sv @@
// Cassette block deframer top level: block state, positions and output queue.
//
// Input stream s_*: one raw image byte per transfer in s_tdata, bit 0 first in
// time; s_tlast marks the final byte of an image. Output stream m_*: one result
// per transfer, m_tuser the kind (payload, summary, truncated), m_tlast set on
// the last result caused by one input byte.
// Eight lanes test every bit alignment of a byte against the sync value at once,
// and a merge stage picks the first hit or the byte at the open block alignment,
// so one byte is taken per cycle. Results are written into a four-entry queue in
// the cycle the byte is taken and show on m_* in the next cycle at the earliest.
// A byte yields zero, one or two results; s_tready is high while the queue has
// room for two, so the input rate is one byte per cycle as long as the output
// side drains, and a stalled receiver stops input after the queue fills.
// Reset (asynchronous, rst_n low) empties the queue, clears all stream state
// to bit position 0 and loads sync_value 60 and emit_payload 1. Config writes
// (cfg_we) land at the next edge and are meant for an idle block.
`include "cassette_block_deframer_core_defines.svh"

module cassette_block_deframer_core
    import cbd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] value, [15:8] block_len, [47:16] lead_len, [79:48] sync_end,
    // [111:80] payload_start, [112] sum_ok, [119:113] zero
    output logic [119:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast,   // last
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_wdata
);

    localparam int P = POSITION_BITS;

    phase_t              phase_reg,   phase_next;
    logic [7:0]          win_reg,     win_next;
    logic [FILL_W-1:0]   fill_reg,    fill_next;
    logic [P-1:0]        bitpos_reg,  bitpos_next;
    logic [P-1:0]        sstart_reg,  sstart_next;
    logic [P-1:0]        syncpos_reg, syncpos_next;
    logic [31:0]         leader_reg,  leader_next;
    logic [LANE_W-1:0]   align_reg,   align_next;
    logic [7:0]          type_reg,    type_next;
    logic [7:0]          len_reg,     len_next;
    logic [7:0]          left_reg,    left_next;
    logic [7:0]          sum_reg,     sum_next;
    logic [7:0]          sync_value_reg;
    logic                emit_payload_reg;

    logic                 accept;
    logic [LANES-1:0]     hits;
    logic [LANES-1:0][7:0] lane_bytes;
    merge_t               merged;
    logic [7:0]           blk_byte;
    logic [P-1:0]         hit_pos;
    logic [P-1:0]         lead_pos;
    logic [P-1:0]         dbit_pos;
    logic [P+31:0]        lead_ext;
    logic [P+31:0]        sync_ext;
    logic [P+31:0]        dbit_ext;
    logic                 ev_valid;
    logic [1:0]           ev_kind;
    logic [7:0]           ev_value;
    logic                 ev_ok;
    logic                 tr_valid;
    result_t              ev_res;
    result_t              tr_res;
    logic                 wr0_valid;
    logic                 wr1_valid;
    result_t              wr0;
    logic                 room2;
    result_t              head;

    assign accept = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            cbd_lane #(.LANE(g)) u_lane (
                .prev_byte  (win_reg),
                .data_byte  (s_tdata),
                .fill       (fill_reg),
                .sync_value (sync_value_reg),
                .lane_byte  (lane_bytes[g]),
                .hit        (hits[g])
            );
        end
    endgenerate

    cbd_merge u_merge (
        .hits       (hits),
        .lane_bytes (lane_bytes),
        .align      (align_reg),
        .merged     (merged)
    );

    assign blk_byte = merged.block_byte;
    assign hit_pos  = bitpos_reg + P'(merged.hit_idx) + P'(1);
    assign lead_pos = hit_pos - P'(8) - sstart_reg;
    assign lead_ext = {32'b0, lead_pos};

    always_comb
    begin
        phase_next   = phase_reg;
        win_next     = s_tdata;
        fill_next    = fill_reg;
        bitpos_next  = bitpos_reg + P'(8);
        sstart_next  = sstart_reg;
        syncpos_next = syncpos_reg;
        leader_next  = leader_reg;
        align_next   = align_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        ev_valid     = 1'b0;
        ev_kind      = KIND_PAYLOAD;
        ev_value     = blk_byte;
        ev_ok        = 1'b0;

        case (phase_reg)
            PH_TYPE:
            begin
                type_next  = blk_byte;
                sum_next   = blk_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = blk_byte;
                left_next  = blk_byte;
                sum_next   = sum_reg + blk_byte;
                phase_next = (blk_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next  = sum_reg + blk_byte;
                ev_valid  = emit_payload_reg;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                ev_valid    = 1'b1;
                ev_kind     = KIND_SUMMARY;
                ev_value    = type_reg;
                ev_ok       = sum_reg == blk_byte;
                phase_next  = PH_SEARCH;
                // bits after the checksum start the next hunt
                fill_next   = FILL_W'(LANES - 1) - FILL_W'(align_reg);
                sstart_next = bitpos_reg + P'(align_reg) + P'(1);
            end
            default:
            begin
                phase_next = PH_SEARCH;
                fill_next  = FILL_FULL;
                if (merged.found)
                begin
                    phase_next   = PH_TYPE;
                    syncpos_next = hit_pos;
                    leader_next  = lead_ext[31:0];
                    align_next   = merged.hit_idx;
                    type_next    = '0;
                    len_next     = '0;
                    left_next    = '0;
                    sum_next     = '0;
                end
            end
        endcase

        tr_valid = s_tlast && (phase_next != PH_SEARCH);
    end

    assign dbit_pos = syncpos_next + P'(16);
    assign sync_ext = {32'b0, syncpos_next};
    assign dbit_ext = {32'b0, dbit_pos};

    always_comb
    begin
        ev_res.kind          = ev_kind;
        ev_res.value         = ev_value;
        ev_res.block_len     = len_next;
        ev_res.lead_len      = leader_next;
        ev_res.sync_end      = sync_ext[31:0];
        ev_res.payload_start = dbit_ext[31:0];
        ev_res.sum_ok        = ev_ok;
        ev_res.last          = !tr_valid;

        tr_res             = ev_res;
        tr_res.kind        = KIND_TRUNC;
        tr_res.value       = type_next;
        tr_res.sum_ok      = 1'b0;
        tr_res.last        = 1'b1;
    end

    assign wr0_valid = accept && (ev_valid || tr_valid);
    assign wr1_valid = accept && ev_valid && tr_valid;
    assign wr0       = ev_valid ? ev_res : tr_res;

    cbd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0_valid (wr0_valid),
        .wr0       (wr0),
        .wr1_valid (wr1_valid),
        .wr1       (tr_res),
        .room2     (room2),
        .rd_valid  (m_tvalid),
        .rd_data   (head),
        .rd_ready  (m_tready)
    );

    assign s_tready = room2;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {7'b0, head.sum_ok, head.payload_start, head.sync_end,
                       head.lead_len, head.block_len, head.value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg   <= SYNC_RESET;
            emit_payload_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_VALUE:   sync_value_reg   <= cfg_wdata;
                REG_EMIT_PAYLOAD: emit_payload_reg <= cfg_wdata[0];
                default:          sync_value_reg   <= sync_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            win_reg     <= '0;
            fill_reg    <= '0;
            bitpos_reg  <= '0;
            sstart_reg  <= '0;
            syncpos_reg <= '0;
            leader_reg  <= '0;
            align_reg   <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            sum_reg     <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // end of image: next byte starts again at bit 0
                phase_reg   <= PH_SEARCH;
                win_reg     <= '0;
                fill_reg    <= '0;
                bitpos_reg  <= '0;
                sstart_reg  <= '0;
                syncpos_reg <= '0;
                leader_reg  <= '0;
                align_reg   <= '0;
                type_reg    <= '0;
                len_reg     <= '0;
                left_reg    <= '0;
                sum_reg     <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                win_reg     <= win_next;
                fill_reg    <= fill_next;
                bitpos_reg  <= bitpos_next;
                sstart_reg  <= sstart_next;
                syncpos_reg <= syncpos_next;
                leader_reg  <= leader_next;
                align_reg   <= align_next;
                type_reg    <= type_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
                sum_reg     <= sum_next;
            end
        end
    end

    `CBD_ASSERT_NXT(a_sync_opens, accept && !s_tlast && phase_reg == PH_SEARCH && merged.found,
        phase_reg == PH_TYPE, "sync hit did not open a block")
    `CBD_ASSERT_NXT(a_eos_clears, accept && s_tlast,
        bitpos_reg == '0 && phase_reg == PH_SEARCH && fill_reg == '0,
        "end of image did not clear stream state")
    `CBD_ASSERT_IMP(a_trunc_in_block, wr0_valid && wr0.kind == KIND_TRUNC,
        s_tlast && !ev_valid, "truncation record without open block at end")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench of the cassette block deframer core.
module tb
    import cbd_pkg::*;
();

    localparam int PB                   = POSITION_BITS_DEF;
    localparam int LIMIT_CYCLES         = 400000;
    localparam int RAND_ITEMS_PER_PHASE = 100;
    localparam int DIR_ROWS             = 21;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       typed;
        result_t    res;
    } stim_row_t;

    // Rows with typed set carry the one result they must give; others go to the predictor.
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h3C, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1,
          '{KIND_PAYLOAD, 8'hFF, 8'd2, 32'd8, 32'd16, 32'd32, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b1,
          '{KIND_PAYLOAD, 8'h00, 8'd2, 32'd8, 32'd16, 32'd32, 1'b0, 1'b1}},
        '{8'h02, 1'b0, 1'b1,
          '{KIND_SUMMARY, 8'h01, 8'd2, 32'd8, 32'd16, 32'd32, 1'b1, 1'b1}},
        // sync right after a block: no leader
        '{8'h3C, 1'b0, 1'b0, '0},
        // image ends just after the type byte
        '{8'h80, 1'b1, 1'b1,
          '{KIND_TRUNC, 8'h80, 8'd0, 32'd0, 32'd64, 32'd80, 1'b0, 1'b1}},
        // sync completes in the final byte of an image
        '{8'h3C, 1'b1, 1'b1,
          '{KIND_TRUNC, 8'h00, 8'd0, 32'd0, 32'd8, 32'd24, 1'b0, 1'b1}},
        // zero length block with a bad checksum
        '{8'h3C, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1,
          '{KIND_SUMMARY, 8'h07, 8'd0, 32'd0, 32'd8, 32'd24, 1'b0, 1'b1}},
        // sync four bits into a byte
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'h53, 1'b0, 1'b0, '0},
        '{8'h21, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0}
    };

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'd0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [7:0]   cfg_wdata = 8'd0;

    cassette_block_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Predictor copy of the registers and the stream state
    logic [7:0]    sync_reg = SYNC_RESET;
    logic          emit_reg = 1'b1;
    phase_t        blk_phase;
    logic [7:0]    win;
    logic [3:0]    fill;
    logic [PB-1:0] pos;
    logic [PB-1:0] search_start;
    logic [PB-1:0] sync_pos;
    logic [31:0]   leader;
    logic [2:0]    bit_cnt;
    logic [7:0]    blk_type;
    logic [7:0]    blk_len;
    logic [7:0]    bytes_left;
    logic [7:0]    run_sum;

    result_t step_res [$];
    result_t deframed_q [$];
    bit      image_bits [$];

    int tx_idle      = 0;
    int rx_stall     = 0;
    int errors       = 0;
    int cycles       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int summaries    = 0;
    int truncations  = 0;

    task automatic clear_stream();
        blk_phase    = PH_SEARCH;
        win          = '0;
        fill         = '0;
        pos          = '0;
        search_start = '0;
        sync_pos     = '0;
        leader       = '0;
        bit_cnt      = '0;
        blk_type     = '0;
        blk_len      = '0;
        bytes_left   = '0;
        run_sum      = '0;
    endtask

    function automatic result_t block_result(logic [1:0] kind, logic [7:0] value, logic ok);
        result_t       r;
        logic [PB-1:0] first_data;
        first_data      = sync_pos + 5'd16;
        r.kind          = kind;
        r.value         = value;
        r.block_len     = blk_len;
        r.lead_len      = leader;
        r.sync_end      = sync_pos[31:0];
        r.payload_start = first_data[31:0];
        r.sum_ok        = ok;
        r.last          = 1'b0;
        return r;
    endfunction

    // Walks the eight bits of one image byte; results land in step_res.
    task automatic deframe_byte(input logic [7:0] d, input logic eos);
        logic [PB-1:0] gap;
        result_t       r;
        step_res.delete();
        for (int i = 0; i < 8; i++)
        begin
            pos = pos + 1'b1;
            win = {d[i], win[7:1]};
            if (blk_phase == PH_SEARCH)
            begin
                if (fill < FILL_FULL)
                    fill = fill + 1'b1;
                if (fill == FILL_FULL && win == sync_reg)
                begin
                    gap        = pos - search_start - 4'd8;
                    sync_pos   = pos;
                    leader     = gap[31:0];
                    blk_phase  = PH_TYPE;
                    bit_cnt    = '0;
                    blk_type   = '0;
                    blk_len    = '0;
                    bytes_left = '0;
                    run_sum    = '0;
                end
            end
            else
            begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt == 3'd0)
                begin
                    case (blk_phase)
                        PH_TYPE:
                        begin
                            blk_type  = win;
                            run_sum   = win;
                            blk_phase = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            blk_len    = win;
                            bytes_left = win;
                            run_sum    = run_sum + win;
                            blk_phase  = (win == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            run_sum = run_sum + win;
                            if (emit_reg)
                                step_res.push_back(block_result(KIND_PAYLOAD, win, 1'b0));
                            bytes_left = bytes_left - 1'b1;
                            if (bytes_left == 8'd0)
                                blk_phase = PH_CHECK;
                        end
                        default:
                        begin
                            step_res.push_back(block_result(KIND_SUMMARY, blk_type,
                                                            run_sum == win));
                            blk_phase    = PH_SEARCH;
                            win          = '0;
                            fill         = '0;
                            search_start = pos;
                        end
                    endcase
                end
            end
        end
        if (eos)
        begin
            if (blk_phase != PH_SEARCH)
                step_res.push_back(block_result(KIND_TRUNC, blk_type, 1'b0));
            clear_stream();
        end
        if (step_res.size() > 0)
        begin
            r      = step_res.pop_back();
            r.last = 1'b1;
            step_res.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic eos, input logic typed,
                             input result_t typed_res);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        deframe_byte(d, eos);
        if (typed)
            deframed_q.push_back(typed_res);
        else
            foreach (step_res[k])
                deframed_q.push_back(step_res[k]);
        items_sent++;
    endtask

    // Stop the sender and let every pending result come out, plus a tail for
    // bytes that produce nothing.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] sync_v, input logic emit_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SYNC_VALUE;
        cfg_wdata <= sync_v;
        @(posedge clk);
        cfg_index <= REG_EMIT_PAYLOAD;
        cfg_wdata <= {7'd0, emit_v};
        @(posedge clk);
        cfg_we   <= 1'b0;
        sync_reg = sync_v;
        emit_reg = emit_v;
    endtask

    task automatic add_bits(input logic [7:0] b);
        for (int i = 0; i < 8; i++)
            image_bits.push_back(b[i]);
    endtask

    // One image: mostly leader + sync + blocks at any bit offset, some with a bad
    // checksum, sometimes cut short or pure noise; the last byte carries tlast.
    task automatic send_image();
        int         blen;
        int         nbytes;
        logic [7:0] b;
        logic [7:0] typ;
        logic [7:0] sum;
        logic       lead;
        image_bits.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                add_bits(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                lead = 1'($urandom_range(1));
                repeat ($urandom_range(0, 24))
                begin
                    image_bits.push_back(lead);
                    lead = ~lead;
                end
                add_bits(sync_reg);
                typ  = 8'($urandom);
                blen = ($urandom_range(49) == 0) ? 255 : $urandom_range(0, 6);
                add_bits(typ);
                add_bits(blen[7:0]);
                sum = typ + blen[7:0];
                repeat (blen)
                begin
                    b = 8'($urandom);
                    add_bits(b);
                    sum = sum + b;
                end
                if ($urandom_range(4) == 0)
                    sum = 8'($urandom);
                add_bits(sum);
                repeat ($urandom_range(0, 6))
                    image_bits.push_back(1'($urandom_range(1)));
            end
            if ($urandom_range(3) == 0)
                image_bits = image_bits[0:$urandom_range(0, image_bits.size() - 1)];
        end
        while (image_bits.size() % 8 != 0)
            image_bits.push_back(1'($urandom_range(1)));
        nbytes = image_bits.size() / 8;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int i = 0; i < 8; i++)
                b[i] = image_bits[8 * k + i];
            send_byte(b, k == nbytes - 1, 1'b0, '0);
        end
        if ($urandom_range(7) == 0)
            drain_results();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_stall);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tdata[79:48],
                    m_tdata[111:80], m_tdata[112], m_tlast};
            results_seen++;
            if (got.kind == KIND_SUMMARY)
                summaries++;
            if (got.kind == KIND_TRUNC)
                truncations++;
            if (deframed_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer: expected none actual %h", $time, got);
            end
            else
            begin
                want = deframed_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("value", 32'(want.value), 32'(got.value));
                check_field("block_len", 32'(want.block_len), 32'(got.block_len));
                check_field("lead_len", want.lead_len, got.lead_len);
                check_field("sync_end", want.sync_end, got.sync_end);
                check_field("payload_start", want.payload_start, got.payload_start);
                check_field("sum_ok", 32'(want.sum_ok), 32'(got.sum_ok));
                check_field("last", 32'(want.last), 32'(got.last));
                check_field("pad", 32'd0, 32'(m_tdata[119:113]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("cassette_block_deframer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int phase_start;
        clear_stream();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers are in force here
        for (int n = 0; n < DIR_ROWS; n++)
            send_byte(DIR_TAB[n].data, DIR_TAB[n].eos, DIR_TAB[n].typed, DIR_TAB[n].res);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle  = 0;
                    rx_stall = 0;
                    write_regs(8'hFF, 1'b1);
                end
                1:
                begin
                    tx_idle  = 48;
                    rx_stall = 0;
                    write_regs(8'h00, 1'b0);
                end
                2:
                begin
                    tx_idle  = 0;
                    rx_stall = 48;
                    write_regs(8'($urandom), 1'b1);
                end
                default:
                begin
                    tx_idle  = 19;
                    rx_stall = 19;
                    write_regs(SYNC_RESET, 1'($urandom_range(1)));
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < RAND_ITEMS_PER_PHASE)
                send_image();
            drain_results();
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d image bytes, checked %0d results (%0d block summaries, %0d truncated).",
                 items_sent, results_seen, summaries, truncations);
        $display("Sync values 0x3C, 0xFF, 0x00 and random; payload output on and off; four idle mixes.");
        if (errors == 0)
            $display("cassette_block_deframer_core: match");
        else
            $display("cassette_block_deframer_core: mismatch");
        $finish;
    end

endmodule
